[rtl/mtrm_pkg.sv]
package mtrm_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TIMEBASE_NUM = 2'd0;
    localparam logic [1:0] CFG_TIMEBASE_DEN = 2'd1;
    localparam logic [1:0] CFG_WALL_WINDOW  = 2'd2;

    // Shared arithmetic unit widths.
    localparam int MUL_A_W  = 64;
    localparam int MUL_B_W  = 48;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W  = PROD_W;
    localparam int DIV_D_W  = 96;
    localparam int QUO_W    = 32;

endpackage

[rtl/mtrm_mul.sv]
module mtrm_mul
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [mtrm_pkg::MUL_A_W-1:0]    a,
    input  logic [mtrm_pkg::MUL_B_W-1:0]    b,
    output logic                            done,
    output logic [mtrm_pkg::PROD_W-1:0]     prod
);

    localparam int AW = mtrm_pkg::MUL_A_W;
    localparam int BW = mtrm_pkg::MUL_B_W;
    localparam int PW = mtrm_pkg::PROD_W;
    localparam int CW = $clog2(BW);

    logic [AW-1:0] a_reg;
    logic [PW-1:0] acc_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [AW:0]   sum;

    // One multiplier bit per cycle: add the multiplicand into the upper half, shift right.
    assign sum = {1'b0, acc_reg[PW-1:BW]} + (acc_reg[0] ? {1'b0, a_reg} : {(AW+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(BW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and product registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            acc_reg <= {{AW{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            acc_reg <= {sum, acc_reg[BW-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

[rtl/mtrm_div.sv]
module mtrm_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [mtrm_pkg::DIV_N_W-1:0]    num,
    input  logic [mtrm_pkg::DIV_D_W-1:0]    den,
    input  logic                            cap32,
    output logic                            done,
    output logic [mtrm_pkg::QUO_W-1:0]      quo
);

    localparam int NW = mtrm_pkg::DIV_N_W;
    localparam int DW = mtrm_pkg::DIV_D_W;
    localparam int QW = mtrm_pkg::QUO_W;
    localparam int CW = $clog2(NW);

    logic [NW-1:0] n_reg;
    logic [DW-1:0] d_reg;
    logic [DW:0]   rem_reg;
    logic [QW:0]   q_reg;
    logic          ovf_reg;
    logic          cap32_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   shifted;
    logic          fits;
    logic [QW:0]   cap;

    // Restoring division, one numerator bit per cycle.
    assign shifted = {rem_reg[DW-1:0], n_reg[NW-1]};
    assign fits    = shifted >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath; quotient bits shifted past the top set a sticky overflow.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg     <= num;
            d_reg     <= den;
            rem_reg   <= '0;
            q_reg     <= '0;
            ovf_reg   <= 1'b0;
            cap32_reg <= cap32;
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[NW-2:0], 1'b0};
            rem_reg <= fits ? shifted - {1'b0, d_reg} : shifted;
            q_reg   <= {q_reg[QW-1:0], fits};
            ovf_reg <= ovf_reg | q_reg[QW];
        end
    end

    // Saturate at the 31-bit or 32-bit limit.
    assign cap  = cap32_reg ? {1'b0, {QW{1'b1}}} : {2'b00, {(QW-1){1'b1}}};
    assign quo  = (ovf_reg || q_reg > cap) ? cap[QW-1:0] : q_reg[QW-1:0];
    assign done = done_reg;

endmodule

[rtl/media_track_rate_monitor.sv]
// Channel  | Direction | Contents
// s_*      | in        | one frame: tdata = dts, payload_bytes, arrival_ms; tuser = flags
// m_*      | out       | one statistics record per frame
// cfg_*    | in        | register writes: timebase_num, timebase_den, wall_window_ms
//
// Each multiply and divide runs bit-serially on the shared arithmetic units.
// Reset is asynchronous and active low; all statistics clear to zero.
// A new frame is taken once the previous record sits in the output register; a stalled
// output only holds the block when the next record is ready to be written.
module media_track_rate_monitor
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // dts[63:0], payload_bytes[87:64], arrival_ms[135:88]
    input  logic [1:0]   s_tuser,   // is_video[0], is_key[1]
    output logic         m_tvalid,
    input  logic         m_tready,
    // bitrate_by_timestamp[30:0], framerate_by_timestamp[62:31],
    // bitrate_by_wallclock[93:63], framerate_by_wallclock[125:94],
    // key_interval_average[157:126], key_interval_latest[188:158],
    // deltas_since_key[219:189], frames_total[267:220], bytes_total[330:268], zero[335:331]
    output logic [335:0] m_tdata,
    output logic [1:0]   m_tuser,   // ts_window_closed[0], wall_window_closed[1]
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int SW = 5;
    localparam logic [SW-1:0] S_IDLE   = 5'd0;
    localparam logic [SW-1:0] S_TS     = 5'd1;
    localparam logic [SW-1:0] S_TSMUL  = 5'd2;
    localparam logic [SW-1:0] S_TSCMP  = 5'd3;
    localparam logic [SW-1:0] S_TSBMUL = 5'd4;
    localparam logic [SW-1:0] S_TSBDIV = 5'd5;
    localparam logic [SW-1:0] S_TSFMUL = 5'd6;
    localparam logic [SW-1:0] S_TSFDIV = 5'd7;
    localparam logic [SW-1:0] S_WALL   = 5'd8;
    localparam logic [SW-1:0] S_WBMUL  = 5'd9;
    localparam logic [SW-1:0] S_WBDIV  = 5'd10;
    localparam logic [SW-1:0] S_WFMUL  = 5'd11;
    localparam logic [SW-1:0] S_WFDIV  = 5'd12;
    localparam logic [SW-1:0] S_CNT    = 5'd13;
    localparam logic [SW-1:0] S_KDIV   = 5'd14;
    localparam logic [SW-1:0] S_OUT    = 5'd15;

    localparam int PW = mtrm_pkg::PROD_W;
    localparam int DW = mtrm_pkg::DIV_D_W;

    logic [SW-1:0] state_reg, state_next;
    logic          go_reg;

    // Configuration.
    logic [31:0] num_reg, den_reg;
    logic [15:0] win_reg;

    // Latched frame.
    logic [63:0] dts_reg;
    logic [23:0] bytes_reg;
    logic [47:0] arr_reg;
    logic        video_reg, key_reg;

    // Window and statistics state.
    logic        ts_valid_reg, wall_started_reg;
    logic [63:0] ts_start_reg, ts_bytes_reg, wall_bytes_reg;
    logic [31:0] ts_frames_reg, wall_frames_reg;
    logic [47:0] wall_start_reg, ft_reg, kc_reg;
    logic [62:0] bt_reg;
    logic [30:0] key_run_reg, delta_run_reg;
    logic [30:0] br_ts_reg, br_w_reg, klast_reg;
    logic [31:0] fr_ts_reg, fr_w_reg, kavg_reg;
    logic        ts_closed_reg, wall_closed_reg;
    logic [95:0] dur_reg;

    // Output register.
    logic         m_tvalid_reg;
    logic [335:0] m_tdata_reg;
    logic [1:0]   m_tuser_reg;

    // Arithmetic unit hookup.
    logic          mul_start, mul_done, div_start, div_done, div_cap32;
    logic [63:0]   mul_a;
    logic [47:0]   mul_b;
    logic [PW-1:0] prod, div_num;
    logic [DW-1:0] div_den;
    logic [31:0]   quo;

    logic [31:0] den_eff;
    logic [15:0] win_eff;
    logic [47:0] elapsed;
    logic [47:0] kc_inc;
    logic [64:0] ts_bsum, w_bsum;
    logic [63:0] bt_sum;

    logic s_fire;
    logic out_free;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign den_eff = (den_reg == 32'd0) ? 32'd1 : den_reg;
    assign win_eff = (win_reg == 16'd0) ? 16'd1 : win_reg;
    assign elapsed = (arr_reg >= wall_start_reg) ? arr_reg - wall_start_reg : 48'd0;
    assign kc_inc  = (kc_reg == {48{1'b1}}) ? kc_reg : kc_reg + 48'd1;
    assign ts_bsum = {1'b0, ts_bytes_reg} + {41'd0, bytes_reg};
    assign w_bsum  = {1'b0, wall_bytes_reg} + {41'd0, bytes_reg};
    assign bt_sum  = {1'b0, bt_reg} + {40'd0, bytes_reg};

    mtrm_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    mtrm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .cap32 (div_cap32),
        .done  (div_done),
        .quo   (quo)
    );

    // Operand selection for the shared units.
    always_comb
    begin
        mul_a     = ts_bytes_reg;
        mul_b     = {16'd0, den_eff};
        div_num   = prod;
        div_den   = dur_reg;
        div_cap32 = 1'b1;
        case (state_reg)
            S_TSMUL:
            begin
                mul_a = dts_reg - ts_start_reg;
                mul_b = {16'd0, num_reg};
            end
            S_TSFMUL:
            begin
                mul_a = {32'd0, ts_frames_reg};
                mul_b = {den_eff, 16'd0};
            end
            S_WBMUL:
            begin
                mul_a = wall_bytes_reg;
                mul_b = 48'd8000;
            end
            S_WFMUL:
            begin
                mul_a = {32'd0, wall_frames_reg};
                mul_b = 48'd65536000;
            end
            S_TSBDIV:
            begin
                div_num   = {prod[PW-4:0], 3'b000};
                div_cap32 = 1'b0;
            end
            S_WBDIV:
            begin
                div_den   = {48'd0, elapsed};
                div_cap32 = 1'b0;
            end
            S_WFDIV:
            begin
                div_den = {48'd0, elapsed};
            end
            S_KDIV:
            begin
                div_num = {48'd0, ft_reg - 48'd1, 16'd0};
                div_den = {48'd0, kc_reg - 48'd1};
            end
            default:
            begin
            end
        endcase
    end

    assign mul_start = go_reg && (state_reg == S_TSMUL || state_reg == S_TSBMUL ||
                                  state_reg == S_TSFMUL || state_reg == S_WBMUL ||
                                  state_reg == S_WFMUL);
    assign div_start = go_reg && (state_reg == S_TSBDIV || state_reg == S_TSFDIV ||
                                  state_reg == S_WBDIV || state_reg == S_WFDIV ||
                                  state_reg == S_KDIV);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_fire) state_next = S_TS;
            S_TS:
            begin
                if (!ts_valid_reg)
                    state_next = S_WALL;
                else if ($signed(dts_reg) >= $signed(ts_start_reg))
                    state_next = S_TSMUL;
                else
                    state_next = S_WALL;
            end
            S_TSMUL:  if (mul_done) state_next = S_TSCMP;
            S_TSCMP:
            begin
                if (dur_reg[95:32] != 64'd0 || dur_reg[31:0] >= den_eff)
                    state_next = S_TSBMUL;
                else
                    state_next = S_WALL;
            end
            S_TSBMUL: if (mul_done) state_next = S_TSBDIV;
            S_TSBDIV: if (div_done) state_next = S_TSFMUL;
            S_TSFMUL: if (mul_done) state_next = S_TSFDIV;
            S_TSFDIV: if (div_done) state_next = S_WALL;
            S_WALL:
            begin
                if (wall_started_reg && elapsed >= {32'd0, win_eff})
                    state_next = S_WBMUL;
                else
                    state_next = S_CNT;
            end
            S_WBMUL:  if (mul_done) state_next = S_WBDIV;
            S_WBDIV:  if (div_done) state_next = S_WFMUL;
            S_WFMUL:  if (mul_done) state_next = S_WFDIV;
            S_WFDIV:  if (div_done) state_next = S_CNT;
            S_CNT:
            begin
                if (video_reg && key_reg && kc_inc >= 48'd2)
                    state_next = S_KDIV;
                else
                    state_next = S_OUT;
            end
            S_KDIV:   if (div_done) state_next = S_OUT;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control and statistics registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            go_reg           <= 1'b0;
            num_reg          <= 32'd1;
            den_reg          <= 32'd1000;
            win_reg          <= 16'd1000;
            ts_valid_reg     <= 1'b0;
            wall_started_reg <= 1'b0;
            ts_start_reg     <= '0;
            ts_frames_reg    <= '0;
            ts_bytes_reg     <= '0;
            wall_start_reg   <= '0;
            wall_frames_reg  <= '0;
            wall_bytes_reg   <= '0;
            ft_reg           <= '0;
            bt_reg           <= '0;
            kc_reg           <= '0;
            key_run_reg      <= '0;
            delta_run_reg    <= '0;
            br_ts_reg        <= '0;
            fr_ts_reg        <= '0;
            br_w_reg         <= '0;
            fr_w_reg         <= '0;
            kavg_reg         <= '0;
            klast_reg        <= '0;
            ts_closed_reg    <= 1'b0;
            wall_closed_reg  <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= (state_next != state_reg);

            // Register writes; an index past the list is ignored.
            if (cfg_we)
            begin
                case (cfg_index)
                    mtrm_pkg::CFG_TIMEBASE_NUM: num_reg <= cfg_data;
                    mtrm_pkg::CFG_TIMEBASE_DEN: den_reg <= cfg_data;
                    mtrm_pkg::CFG_WALL_WINDOW:  win_reg <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end

            // Output valid: set when a record is written, cleared when it is taken.
            if (state_reg == S_OUT && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_fire)
                    begin
                        ts_closed_reg   <= 1'b0;
                        wall_closed_reg <= 1'b0;
                    end
                end
                S_TS:
                begin
                    if (!ts_valid_reg)
                    begin
                        ts_valid_reg  <= 1'b1;
                        ts_start_reg  <= dts_reg;
                        ts_frames_reg <= '0;
                        ts_bytes_reg  <= '0;
                    end
                end
                S_TSBDIV:
                begin
                    if (div_done)
                        br_ts_reg <= quo[30:0];
                end
                S_TSFDIV:
                begin
                    if (div_done)
                    begin
                        fr_ts_reg     <= quo;
                        ts_start_reg  <= dts_reg;
                        ts_frames_reg <= '0;
                        ts_bytes_reg  <= '0;
                        ts_closed_reg <= 1'b1;
                    end
                end
                S_WALL:
                begin
                    if (!wall_started_reg)
                    begin
                        wall_started_reg <= 1'b1;
                        wall_start_reg   <= arr_reg;
                    end
                end
                S_WBDIV:
                begin
                    if (div_done)
                        br_w_reg <= quo[30:0];
                end
                S_WFDIV:
                begin
                    if (div_done)
                    begin
                        fr_w_reg        <= quo;
                        wall_start_reg  <= arr_reg;
                        wall_frames_reg <= '0;
                        wall_bytes_reg  <= '0;
                        wall_closed_reg <= 1'b1;
                    end
                end
                S_CNT:
                begin
                    // Saturating totals and window sums.
                    if (ft_reg != {48{1'b1}})
                        ft_reg <= ft_reg + 48'd1;
                    bt_reg <= bt_sum[63] ? {63{1'b1}} : bt_sum[62:0];
                    if (ts_frames_reg != {32{1'b1}})
                        ts_frames_reg <= ts_frames_reg + 32'd1;
                    if (wall_frames_reg != {32{1'b1}})
                        wall_frames_reg <= wall_frames_reg + 32'd1;
                    ts_bytes_reg   <= ts_bsum[64] ? {64{1'b1}} : ts_bsum[63:0];
                    wall_bytes_reg <= w_bsum[64] ? {64{1'b1}} : w_bsum[63:0];

                    // Key-frame interval tracking for video.
                    if (video_reg && key_reg)
                    begin
                        kc_reg        <= kc_inc;
                        klast_reg     <= key_run_reg;
                        key_run_reg   <= 31'd1;
                        delta_run_reg <= '0;
                    end
                    else if (video_reg && key_run_reg != 31'd0)
                    begin
                        if (key_run_reg != {31{1'b1}})
                            key_run_reg <= key_run_reg + 31'd1;
                        if (delta_run_reg != {31{1'b1}})
                            delta_run_reg <= delta_run_reg + 31'd1;
                    end
                end
                S_KDIV:
                begin
                    if (div_done)
                        kavg_reg <= quo;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Frame capture, product capture and output record.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            dts_reg   <= s_tdata[63:0];
            bytes_reg <= s_tdata[87:64];
            arr_reg   <= s_tdata[135:88];
            video_reg <= s_tuser[0];
            key_reg   <= s_tuser[1];
        end
        if (state_reg == S_TSMUL && mul_done)
            dur_reg <= prod[95:0];
        if (state_reg == S_OUT && out_free)
        begin
            m_tdata_reg <= {5'd0, bt_reg, ft_reg, delta_run_reg, klast_reg, kavg_reg,
                            fr_w_reg, br_w_reg, fr_ts_reg, br_ts_reg};
            m_tuser_reg <= {wall_closed_reg, ts_closed_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[verif/media_track_rate_monitor_tb.sv]
`timescale 1ns / 1ps

module media_track_rate_monitor_tb;

    localparam logic [63:0] CAP31 = 64'h7FFF_FFFF;
    localparam logic [63:0] CAP32 = 64'hFFFF_FFFF;
    localparam logic [63:0] CAP48 = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] CAP63 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] CAP64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int DRAIN_CYCLES = 1000;

    typedef struct packed {
        logic [63:0] dts;
        logic [23:0] bytes;
        logic [47:0] arrival;
        logic        video;
        logic        key;
    } frame_t;

    typedef struct packed {
        logic [30:0] br_ts;
        logic [31:0] fr_ts;
        logic [30:0] br_wall;
        logic [31:0] fr_wall;
        logic [31:0] key_avg;
        logic [30:0] key_last;
        logic [30:0] deltas;
        logic [47:0] frames;
        logic [62:0] bytes;
        logic        ts_closed;
        logic        wall_closed;
    } stats_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [335:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    media_track_rate_monitor uut (.*);

    // Pending frames, expected records and run bookkeeping.
    frame_t frame_queue[$];
    stats_t stats_queue[$];
    int     src_idle;
    int     snk_idle;
    int     errors;
    int     frames_sent;
    int     records_seen;
    int     ts_closes;
    int     wall_closes;
    logic   req_taken;

    // Predictor configuration and state.
    logic [63:0] tb_num, tb_den, tb_win;
    logic        ts_open, wall_open;
    logic [63:0] ts_start, ts_frames, ts_bytes;
    logic [63:0] wall_start, wall_frames, wall_bytes;
    logic [63:0] total_frames, total_bytes, total_keys;
    logic [63:0] key_run, delta_run;
    logic [63:0] rate_br_ts, rate_fr_ts, rate_br_wall, rate_fr_wall, rate_key_avg, rate_key_last;

    // Stimulus generator state.
    logic [63:0] gen_dts;
    logic [47:0] gen_arrival;

    always #4 clk = ~clk;

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (a > cap || s > {1'b0, cap}) ? cap : s[63:0];
    endfunction

    function automatic logic [63:0] sat_div(logic [127:0] n, logic [127:0] d, logic [63:0] cap);
        logic [127:0] q;
        q = n / d;
        return (q > {64'b0, cap}) ? cap : q[63:0];
    endfunction

    // Advance the statistics by one frame and return the record it should produce.
    function automatic stats_t frame_stats(frame_t f);
        stats_t r;
        logic [127:0] dur, den, elapsed, q;
        r.ts_closed = 1'b0;
        r.wall_closed = 1'b0;
        if (!ts_open)
        begin
            ts_open = 1'b1;
            ts_start = f.dts;
            ts_frames = 0;
            ts_bytes = 0;
        end
        else if ($signed(f.dts) >= $signed(ts_start))
        begin
            den = (tb_den == 0) ? 128'd1 : {64'b0, tb_den};
            dur = {64'b0, f.dts - ts_start} * {64'b0, tb_num};
            if (dur >= den)
            begin
                rate_br_ts = sat_div(({64'b0, ts_bytes} * den) << 3, dur, CAP31);
                rate_fr_ts = sat_div({64'b0, ts_frames} * (den << 16), dur, CAP32);
                ts_start = f.dts;
                ts_frames = 0;
                ts_bytes = 0;
                r.ts_closed = 1'b1;
            end
        end
        if (!wall_open)
        begin
            wall_open = 1'b1;
            wall_start = {16'b0, f.arrival};
        end
        else
        begin
            elapsed = ({16'b0, f.arrival} >= wall_start) ? {80'b0, f.arrival} - wall_start : 0;
            if (elapsed >= ((tb_win == 0) ? 128'd1 : {64'b0, tb_win}))
            begin
                rate_br_wall = sat_div({64'b0, wall_bytes} * 128'd8000, elapsed, CAP31);
                rate_fr_wall = sat_div({64'b0, wall_frames} * 128'd65536000, elapsed, CAP32);
                wall_start = {16'b0, f.arrival};
                wall_frames = 0;
                wall_bytes = 0;
                r.wall_closed = 1'b1;
            end
        end
        total_frames = sat_add(total_frames, 1, CAP48);
        total_bytes = sat_add(total_bytes, {40'b0, f.bytes}, CAP63);
        ts_frames = sat_add(ts_frames, 1, CAP32);
        ts_bytes = sat_add(ts_bytes, {40'b0, f.bytes}, CAP64);
        wall_frames = sat_add(wall_frames, 1, CAP32);
        wall_bytes = sat_add(wall_bytes, {40'b0, f.bytes}, CAP64);
        // Key-frame statistics apply to video tracks only.
        if (f.video)
        begin
            if (f.key)
            begin
                total_keys = sat_add(total_keys, 1, CAP48);
                if (total_keys >= 2)
                begin
                    q = {64'b0, (total_frames - 1) << 16} / {64'b0, total_keys - 1};
                    rate_key_avg = (q > {64'b0, CAP32}) ? CAP32 : q[63:0];
                end
                rate_key_last = key_run;
                key_run = 1;
                delta_run = 0;
            end
            else if (key_run > 0)
            begin
                key_run = sat_add(key_run, 1, CAP31);
                delta_run = sat_add(delta_run, 1, CAP31);
            end
        end
        r.br_ts = rate_br_ts[30:0];
        r.fr_ts = rate_fr_ts[31:0];
        r.br_wall = rate_br_wall[30:0];
        r.fr_wall = rate_fr_wall[31:0];
        r.key_avg = rate_key_avg[31:0];
        r.key_last = rate_key_last[30:0];
        r.deltas = delta_run[30:0];
        r.frames = total_frames[47:0];
        r.bytes = total_bytes[62:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH record %0d %s: got %0h expected %0h", records_seen, field, got, want);
        errors++;
    endtask

    task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch(field, got, want);
    endtask

    // Driver: requests change at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle);
            if (!s_tvalid || req_taken)
            begin
                if (frame_queue.size() > 0 && $urandom_range(0, 99) >= src_idle)
                begin
                    frame_t f;
                    f = frame_queue[0];
                    frame_queue.delete(0);
                    s_tdata <= {f.arrival, f.bytes, f.dts};
                    s_tuser <= {f.key, f.video};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: accepted requests feed the predictor, accepted records are checked.
    always @(posedge clk)
    begin
        stats_t want, got;
        frame_t f;
        req_taken = rst_n && s_tvalid && s_tready;
        if (req_taken)
        begin
            f.dts = s_tdata[63:0];
            f.bytes = s_tdata[87:64];
            f.arrival = s_tdata[135:88];
            f.video = s_tuser[0];
            f.key = s_tuser[1];
            want = frame_stats(f);
            stats_queue.insert(stats_queue.size(), want);
            frames_sent++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.br_ts = m_tdata[30:0];
            got.fr_ts = m_tdata[62:31];
            got.br_wall = m_tdata[93:63];
            got.fr_wall = m_tdata[125:94];
            got.key_avg = m_tdata[157:126];
            got.key_last = m_tdata[188:158];
            got.deltas = m_tdata[219:189];
            got.frames = m_tdata[267:220];
            got.bytes = m_tdata[330:268];
            got.ts_closed = m_tuser[0];
            got.wall_closed = m_tuser[1];
            if (stats_queue.size() == 0)
                report_mismatch("record with nothing expected", 64'd1, 64'd0);
            else
            begin
                want = stats_queue[0];
                stats_queue.delete(0);
                check_field("bitrate_by_timestamp", got.br_ts, want.br_ts);
                check_field("framerate_by_timestamp", got.fr_ts, want.fr_ts);
                check_field("bitrate_by_wallclock", got.br_wall, want.br_wall);
                check_field("framerate_by_wallclock", got.fr_wall, want.fr_wall);
                check_field("key_interval_average", got.key_avg, want.key_avg);
                check_field("key_interval_latest", got.key_last, want.key_last);
                check_field("deltas_since_key", got.deltas, want.deltas);
                check_field("frames_total", got.frames, want.frames);
                check_field("bytes_total", got.bytes, want.bytes);
                check_field("ts_window_closed", got.ts_closed, want.ts_closed);
                check_field("wall_window_closed", got.wall_closed, want.wall_closed);
                if (want.ts_closed)
                    ts_closes++;
                if (want.wall_closed)
                    wall_closes++;
            end
            records_seen++;
        end
    end

    task automatic push_frame(logic [63:0] dts, logic [23:0] bytes, logic [47:0] arrival,
                              logic video, logic key);
        frame_t f;
        f.dts = dts;
        f.bytes = bytes;
        f.arrival = arrival;
        f.video = video;
        f.key = key;
        frame_queue.insert(frame_queue.size(), f);
    endtask

    // One random frame: mostly a plausible stream, some jumps and pure noise.
    task automatic push_random_frame();
        int sel;
        logic [23:0] bytes;
        sel = $urandom_range(0, 99);
        bytes = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 60000));
        if (sel < 8)
        begin
            push_frame({$urandom, $urandom}, 24'($urandom), {16'($urandom), $urandom},
                       1'($urandom), 1'($urandom));
            return;
        end
        if (sel < 11)
            gen_dts = gen_dts - $urandom_range(1, 500);
        else if (sel < 13)
            gen_dts = gen_dts + {32'b0, $urandom};
        else
            gen_dts = gen_dts + $urandom_range(0, 60);
        if (sel >= 95)
            gen_arrival = gen_arrival - $urandom_range(1, 300);
        else if (sel >= 93)
            gen_arrival = gen_arrival + $urandom_range(2000, 200000);
        else
            gen_arrival = gen_arrival + $urandom_range(0, 70);
        push_frame(gen_dts, bytes, gen_arrival, $urandom_range(0, 9) != 0,
                   $urandom_range(0, 9) == 0);
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (index)
            mtrm_pkg::CFG_TIMEBASE_NUM: tb_num = {32'b0, value};
            mtrm_pkg::CFG_TIMEBASE_DEN: tb_den = {32'b0, value};
            mtrm_pkg::CFG_WALL_WINDOW:  tb_win = {48'b0, value[15:0]};
            default: ;
        endcase
    endtask

    // Hold the sender until every expected record has arrived and the block is quiet.
    task automatic wait_drained();
        while (frame_queue.size() > 0 || s_tvalid || stats_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int src, int snk, logic [31:0] num, logic [31:0] den,
                             logic [15:0] win, int count);
        wait_drained();
        write_reg(mtrm_pkg::CFG_TIMEBASE_NUM, num);
        write_reg(mtrm_pkg::CFG_TIMEBASE_DEN, den);
        write_reg(mtrm_pkg::CFG_WALL_WINDOW, {16'b0, win});
        src_idle = src;
        snk_idle = snk;
        repeat (count) push_random_frame();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = mtrm_pkg::CFG_TIMEBASE_NUM;
        cfg_data = '0;
        src_idle = 0;
        snk_idle = 0;
        errors = 0;
        frames_sent = 0;
        records_seen = 0;
        ts_closes = 0;
        wall_closes = 0;
        req_taken = 1'b0;
        tb_num = 1;
        tb_den = 1000;
        tb_win = 1000;
        ts_open = 1'b0;
        wall_open = 1'b0;
        {ts_start, ts_frames, ts_bytes} = '0;
        {wall_start, wall_frames, wall_bytes} = '0;
        {total_frames, total_bytes, total_keys, key_run, delta_run} = '0;
        {rate_br_ts, rate_fr_ts, rate_br_wall, rate_fr_wall, rate_key_avg, rate_key_last} = '0;
        gen_dts = 64'd5000;
        gen_arrival = 48'd100000;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames at reset settings: first frame, delta before any key, first and
        // second key, non-video key, huge and empty payloads, both axes going backwards.
        push_frame(64'd1000, 24'd0, 48'd0, 1'b1, 1'b0);
        push_frame(64'd1010, 24'hFFFFFF, 48'd10, 1'b1, 1'b0);
        push_frame(64'd1020, 24'hFFFFFF, 48'd20, 1'b1, 1'b1);
        push_frame(64'd1030, 24'hFFFFFF, 48'd30, 1'b1, 1'b0);
        push_frame(64'd1040, 24'hFFFFFF, 48'd40, 1'b0, 1'b1);
        push_frame(64'd1050, 24'hFFFFFF, 48'd50, 1'b1, 1'b1);
        push_frame(64'd900, 24'd100, 48'd20, 1'b1, 1'b0);
        push_frame(64'd2000, 24'hFFFFFF, 48'd1000, 1'b1, 1'b0);
        push_frame(64'd3000, 24'd0, 48'd2000, 1'b1, 1'b1);
        push_frame(64'h7FFF_FFFF_FFFF_FFFF, 24'd5, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
        push_frame(64'h8000_0000_0000_0000, 24'd5, 48'd0, 1'b1, 1'b0);
        push_frame(64'h8000_0000_0000_0000, 24'd5, 48'd5000, 1'b1, 1'b1);
        push_frame(64'h7FFF_FFFF_FFFF_FFFF, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1);
        push_frame(64'hFFFF_FFFF_FFFF_FFFF, 24'd1, 48'd3, 1'b0, 1'b0);
        repeat (230) push_random_frame();

        run_phase(82, 0, 32'd1, 32'd30, 16'd50, 240);
        run_phase(0, 82, 32'd0, 32'd1, 16'd0, 240);
        run_phase(32, 32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 220);
        run_phase(0, 0, 32'd1, 32'd0, 16'd1, 220);
        run_phase(32, 32, 32'd3, 32'd90000, 16'd1000, 60);

        wait_drained();
        $display("Checked %0d of %0d frames over six register settings and four idle mixes.",
                 records_seen, frames_sent);
        $display("Timestamp windows closed %0d times, wall-clock windows %0d times.",
                 ts_closes, wall_closes);
        if (errors == 0 && stats_queue.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("Timeout with %0d records outstanding.", stats_queue.size());
        $display("simulation failed");
        $finish;
    end

endmodule
